[src/bpa_pkg.sv]
// shared types and codes for the bitmap page allocator
`default_nettype none

package bpa_pkg;

  localparam int PAGE_W  = 12;
  localparam int COUNT_W = 13;
  localparam int CFG_W   = 13;

  // item modes
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_INIT  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OOM   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FREE  = 2'd3;

  // configuration register indexes
  localparam logic CFG_TOTAL    = 1'b0;
  localparam logic CFG_RESERVED = 1'b1;

  typedef struct packed {
    logic [1:0]        mode;
    logic [PAGE_W-1:0] page_index;
  } in_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  result_page;
    logic [1:0]         status;
    logic [COUNT_W-1:0] allocated_count;
  } out_t;

  // source of the result page
  typedef enum logic [1:0] {
    PG_ZERO  = 2'd0,
    PG_FOUND = 2'd1,
    PG_IDX   = 2'd2
  } page_sel_t;

  // controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       row_clr;
    logic       row_inc;
    logic       rd_en;
    logic       rd_idx;
    logic       wr_sweep;
    logic       sweep_zero;
    logic       wr_alloc;
    logic       wr_free;
    logic       cnt_init;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_load;
    page_sel_t  res_page;
    logic [1:0] res_status;
    logic       out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       row_beyond;
    logic       row_last;
    logic       row_end;
    logic       found;
    logic       idx_range;
    logic       idx_busy;
    logic       out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

[src/bpa_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/bpa_ctrl.sv]
// controller state machine of the bitmap page allocator
`default_nettype none

module bpa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bpa_pkg::dp_sts_t  sts,
  output bpa_pkg::dp_cmd_t       cmd
);

  import bpa_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_DECODE = 9'b000000100,
    S_A_RD   = 9'b000001000,
    S_A_CHK  = 9'b000010000,
    S_F_RD   = 9'b000100000,
    S_F_CHK  = 9'b001000000,
    S_INIT   = 9'b010000000,
    S_RESP   = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.wr_sweep   = 1'b1;
        cmd.sweep_zero = 1'b1;
        cmd.row_inc    = 1'b1;
        if (sts.row_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cmd.row_clr = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.mode)
          MODE_ALLOC: begin
            if (sts.row_beyond) begin
              cmd.res_load   = 1'b1;
              cmd.res_page   = PG_ZERO;
              cmd.res_status = ST_OOM;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_A_RD;
            end
          end
          MODE_FREE: begin
            if (sts.idx_range) begin
              cmd.res_load   = 1'b1;
              cmd.res_page   = PG_IDX;
              cmd.res_status = ST_RANGE;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_F_RD;
            end
          end
          MODE_INIT: begin
            state_nxt = S_INIT;
          end
          default: begin
            cmd.res_load   = 1'b1;
            cmd.res_page   = PG_ZERO;
            cmd.res_status = ST_OK;
            state_nxt      = S_RESP;
          end
        endcase
      end
      S_A_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_A_CHK;
      end
      S_A_CHK: begin
        if (sts.found) begin
          cmd.wr_alloc   = 1'b1;
          cmd.cnt_inc    = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_page   = PG_FOUND;
          cmd.res_status = ST_OK;
          state_nxt      = S_RESP;
        end else if (sts.row_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_page   = PG_ZERO;
          cmd.res_status = ST_OOM;
          state_nxt      = S_RESP;
        end else begin
          cmd.row_inc = 1'b1;
          state_nxt   = S_A_RD;
        end
      end
      S_F_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_idx = 1'b1;
        state_nxt  = S_F_CHK;
      end
      S_F_CHK: begin
        cmd.res_load = 1'b1;
        cmd.res_page = PG_IDX;
        if (sts.idx_busy) begin
          cmd.wr_free    = 1'b1;
          cmd.cnt_dec    = 1'b1;
          cmd.res_status = ST_OK;
        end else begin
          cmd.res_status = ST_FREE;
        end
        state_nxt = S_RESP;
      end
      S_INIT: begin
        cmd.wr_sweep = 1'b1;
        cmd.row_inc  = 1'b1;
        if (sts.row_end) begin
          cmd.cnt_init   = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_page   = PG_ZERO;
          cmd.res_status = ST_OK;
          state_nxt      = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

[src/bpa_dp.sv]
// datapath of the bitmap page allocator: row scan, masks, count and result
`default_nettype none

module bpa_dp #(
  parameter int MAX_PAGES = 4096,
  localparam int WORD_W = (MAX_PAGES >= 64) ? 64 : 8,
  localparam int ROWS   = (MAX_PAGES + WORD_W - 1) / WORD_W,
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire bpa_pkg::dp_cmd_t           cmd,
  output bpa_pkg::dp_sts_t                sts,
  input  wire logic [bpa_pkg::CFG_W-1:0]  page_limit,
  input  wire logic [bpa_pkg::CFG_W-1:0]  reserved_pages,
  input  wire bpa_pkg::in_t               in_data,
  input  wire logic                       out_stall,
  output logic                            out_valid,
  output bpa_pkg::out_t                   out_data,
  output logic                            ram_wr_en,
  output logic [ROW_W-1:0]                ram_wr_addr,
  output logic [WORD_W-1:0]               ram_wr_data,
  output logic                            ram_rd_en,
  output logic [ROW_W-1:0]                ram_rd_addr,
  input  wire logic [WORD_W-1:0]          ram_rd_data
);

  import bpa_pkg::*;

  localparam int BIT_W = $clog2(WORD_W);
  localparam int CNT_W = $clog2(MAX_PAGES + 1);

  logic [1:0]        mode_r;
  logic [PAGE_W-1:0] idx_r;
  logic [ROW_W-1:0]  row_r;
  logic [ROW_W-1:0]  row_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [PAGE_W-1:0] res_page_r;
  logic [1:0]        res_status_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  out_t              out_data_r;

  logic [CNT_W-1:0]  eff;
  logic [CNT_W-1:0]  res_eff;
  logic [31:0]       row_base;
  logic [WORD_W-1:0] free_bits;
  logic [BIT_W-1:0]  first_bit;
  logic [31:0]       found_page;
  logic [ROW_W-1:0]  idx_row;
  logic [BIT_W-1:0]  idx_bit;
  logic [WORD_W-1:0] sweep_word;

  // bits of the row at base whose page index is below lim
  function automatic logic [WORD_W-1:0] low_mask(input logic [31:0] lim,
                                                 input logic [31:0] base);
    logic [31:0]       rem;
    logic [WORD_W-1:0] m;
    if (lim <= base) begin
      rem = '0;
    end else if ((lim - base) >= 32'(WORD_W)) begin
      rem = 32'(WORD_W);
    end else begin
      rem = lim - base;
    end
    for (int j = 0; j < WORD_W; j++) begin
      m[j] = (32'(j) < rem);
    end
    return m;
  endfunction

  // clamp config to the physical bitmap
  assign eff     = (32'(page_limit) > 32'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                      : CNT_W'(page_limit);
  assign res_eff = (32'(reserved_pages) > 32'(eff)) ? eff : CNT_W'(reserved_pages);

  assign row_base  = 32'(row_r) << BIT_W;
  assign free_bits = ~ram_rd_data & low_mask(32'(eff), row_base);

  // lowest free bit of the row
  always_comb begin
    first_bit = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        first_bit = BIT_W'(j);
      end
    end
  end

  assign found_page = row_base + 32'(first_bit);
  assign idx_row    = ROW_W'(32'(idx_r) >> BIT_W);
  assign idx_bit    = idx_r[BIT_W-1:0];
  assign sweep_word = cmd.sweep_zero ? '0 : low_mask(32'(res_eff), row_base);

  always_comb begin
    sts.mode       = mode_r;
    sts.row_beyond = (row_base >= 32'(eff));
    sts.row_end    = (row_r == ROW_W'(ROWS - 1));
    sts.row_last   = sts.row_end || ((row_base + 32'(WORD_W)) >= 32'(eff));
    sts.found      = |free_bits;
    sts.idx_range  = (32'(idx_r) >= 32'(eff));
    sts.idx_busy   = ram_rd_data[idx_bit];
    sts.out_free   = !out_valid_r || !out_stall;
  end

  // bitmap port drive
  always_comb begin
    ram_wr_en   = cmd.wr_sweep || cmd.wr_alloc || cmd.wr_free;
    ram_wr_addr = cmd.wr_free ? idx_row : row_r;
    if (cmd.wr_alloc) begin
      ram_wr_data = ram_rd_data | (WORD_W'(1) << first_bit);
    end else if (cmd.wr_free) begin
      ram_wr_data = ram_rd_data & ~(WORD_W'(1) << idx_bit);
    end else begin
      ram_wr_data = sweep_word;
    end
    ram_rd_en   = cmd.rd_en;
    ram_rd_addr = cmd.rd_idx ? idx_row : row_r;
  end

  always_comb begin
    row_nxt = row_r;
    if (cmd.row_clr) begin
      row_nxt = '0;
    end else if (cmd.row_inc) begin
      row_nxt = row_r + ROW_W'(1);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_init) begin
      cnt_nxt = res_eff;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec && (cnt_r != '0)) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= in_data.mode;
      idx_r  <= in_data.page_index;
    end
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      case (cmd.res_page)
        PG_FOUND: res_page_r <= PAGE_W'(found_page);
        PG_IDX:   res_page_r <= idx_r;
        default:  res_page_r <= '0;
      endcase
    end
    if (cmd.out_load) begin
      out_data_r.result_page     <= res_page_r;
      out_data_r.status          <= res_status_r;
      out_data_r.allocated_count <= COUNT_W'(cnt_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[src/bitmap_page_allocator.sv]
// top level of the first-fit bitmap page allocator
//
// usage: items enter on in_valid/in_stall with in_data {mode, page_index};
// each item gives exactly one result transfer on out_valid/out_stall with
// out_data {result_page, status, allocated_count}. a transfer happens at a
// rising edge with valid high and stall low. the bitmap sits in a ram of
// 64-bit rows (8-bit rows when MAX_PAGES is below 64), one row per access.
// steps of each item, from acceptance to the result, with the output free:
//   allocate   a read and a check per row (first-fit, up to every row of the bitmap)
//   free       a read and a check of the index row (no read if the index is out of range)
//   initialize a write sweep over the whole bitmap
//   unused     an ok result with no bitmap access
// the registered ram read sets the scan speed: each row costs a read and a check.
// one item is in flight at a time; the next is taken once the result sits in the
// output register, even if stalled.
// a stalled result holds; a new result waits until the output slot frees.
// reset (rst_n low, synchronous) sets the page limit to 4096, reserved_pages
// to 1, the count to zero, and starts a clearing pass of one row per cycle
// with in_stall high; config writes on cfg_we/cfg_index/cfg_wdata are taken at
// any time, meant for idle periods
`default_nettype none

module bitmap_page_allocator #(
  parameter int MAX_PAGES = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire bpa_pkg::in_t              in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output bpa_pkg::out_t                  out_data,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [bpa_pkg::CFG_W-1:0] cfg_wdata
);

  import bpa_pkg::*;

  localparam int WORD_W = (MAX_PAGES >= 64) ? 64 : 8;
  localparam int ROWS   = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

  // configuration registers
  logic [CFG_W-1:0] total_r;
  logic [CFG_W-1:0] total_nxt;
  logic [CFG_W-1:0] reserved_r;
  logic [CFG_W-1:0] reserved_nxt;

  dp_cmd_t cmd;
  dp_sts_t sts;

  logic              ram_wr_en;
  logic [ROW_W-1:0]  ram_wr_addr;
  logic [WORD_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [ROW_W-1:0]  ram_rd_addr;
  logic [WORD_W-1:0] ram_rd_data;

  always_comb begin
    total_nxt    = total_r;
    reserved_nxt = reserved_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TOTAL:    total_nxt    = cfg_wdata;
        CFG_RESERVED: reserved_nxt = cfg_wdata;
        default:      total_nxt    = total_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= CFG_W'(4096);
      reserved_r <= CFG_W'(1);
    end else begin
      total_r    <= total_nxt;
      reserved_r <= reserved_nxt;
    end
  end

  // sequencing of sweeps, scans and responses
  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // masks, first-free search, count and output register
  bpa_dp #(
    .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .page_limit     (total_r),
    .reserved_pages (reserved_r),
    .in_data        (in_data),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .ram_wr_en      (ram_wr_en),
    .ram_wr_addr    (ram_wr_addr),
    .ram_wr_data    (ram_wr_data),
    .ram_rd_en      (ram_rd_en),
    .ram_rd_addr    (ram_rd_addr),
    .ram_rd_data    (ram_rd_data)
  );

  // in-use bitmap, one row of pages per entry
  bpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // one item in flight: an accepted item blocks the next cycle
  a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item is in flight");

  // the bitmap is only written while an item or the clearing pass runs
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !ram_wr_en)
    else $error("bitmap written while idle");

  // a new result appears only as the controller returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result presented while the controller is busy");

  // row writes stay inside the bitmap
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (32'(ram_wr_addr) < 32'(ROWS)))
    else $error("bitmap write beyond the last row");

  // the page count never exceeds the bitmap size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.allocated_count) <= 32'(MAX_PAGES)))
    else $error("allocated count above the bitmap size");

endmodule

`default_nettype wire

[tb/bitmap_page_allocator_tb.sv]
// self-checking testbench for the first-fit bitmap page allocator
`default_nettype none

module bitmap_page_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpa_pkg::*;

  localparam int MAX_PAGES = 4096;
  // mode 3 has no name in the package; the block must leave its state alone
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RAND_PHASES = 11;
  localparam int ITEMS_PER_PHASE = 102;

  // one row of the directed table: either a register write or an item
  typedef struct {
    bit                 cfg_row;
    logic               cfg_sel;
    logic [CFG_W-1:0]   cfg_val;
    in_t                item;
    bit                 typed;   // want holds a hand-written result
    out_t               want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_t                in_data;
  logic               out_valid;
  logic               out_stall;
  out_t               out_data;
  logic               cfg_we;
  logic               cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;

  // predictor state: bitmap, count and the two registers as the block sees them
  bit                 page_busy [MAX_PAGES];
  int unsigned        pages_in_use;
  logic [CFG_W-1:0]   total_reg;
  logic [CFG_W-1:0]   reserved_reg;

  out_t               pending_results [$];
  stim_row_t          dir_rows [$];
  int                 mismatches;
  int                 items_sent;
  int                 results_seen;
  int                 settings_used;
  int                 status_seen [4];

  bitmap_page_allocator #(
    .MAX_PAGES(MAX_PAGES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // a total above the bitmap size acts as the full bitmap
  function automatic int unsigned managed_pages();
    return (total_reg > MAX_PAGES) ? MAX_PAGES : int'(total_reg);
  endfunction

  // applies one item to the predictor state and returns the result it gives
  function automatic out_t step_allocator(in_t it);
    int unsigned lim;
    int unsigned keep;
    out_t        r;
    lim = managed_pages();
    r = '0;
    r.status = ST_OK;
    case (it.mode)
      MODE_ALLOC: begin
        // first fit below the managed total, else out of memory with page 0
        r.status = ST_OOM;
        for (int i = 0; i < lim; i++) begin
          if (!page_busy[i]) begin
            page_busy[i] = 1'b1;
            pages_in_use++;
            r.result_page = PAGE_W'(i);
            r.status = ST_OK;
            break;
          end
        end
      end
      MODE_FREE: begin
        r.result_page = it.page_index;
        if (it.page_index >= lim) begin
          r.status = ST_RANGE;
        end else if (!page_busy[it.page_index]) begin
          r.status = ST_FREE;
        end else begin
          page_busy[it.page_index] = 1'b0;
          if (pages_in_use > 0) pages_in_use--;
        end
      end
      MODE_INIT: begin
        // reserve is clipped to the managed total
        keep = (reserved_reg > lim) ? lim : int'(reserved_reg);
        page_busy = '{default: 1'b0};
        for (int i = 0; i < keep; i++) page_busy[i] = 1'b1;
        pages_in_use = keep;
      end
      default: begin
        // unused mode: nothing changes, page 0, ok, current count
      end
    endcase
    r.allocated_count = COUNT_W'(pages_in_use);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns  %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // every result transfer is matched against the oldest expectation
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing pending", int'(out_data), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_page !== want.result_page)
          report_mismatch("result_page", int'(out_data.result_page), int'(want.result_page));
        if (out_data.status !== want.status)
          report_mismatch("status", int'(out_data.status), int'(want.status));
        if (out_data.allocated_count !== want.allocated_count)
          report_mismatch("allocated_count", int'(out_data.allocated_count),
                          int'(want.allocated_count));
        status_seen[want.status]++;
        results_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // a page that is in use below the managed total, if there is one
  function automatic int unsigned pick_busy_page(int unsigned lim);
    int unsigned start;
    int unsigned p;
    if (lim == 0) return $urandom_range(0, MAX_PAGES - 1);
    start = $urandom_range(0, lim - 1);
    for (int k = 0; k < lim; k++) begin
      p = (start + k) % lim;
      if (page_busy[p]) return p;
    end
    return start;
  endfunction

  // random item biased toward alloc/free traffic on live pages
  function automatic in_t pick_random_item();
    in_t         it;
    int unsigned lim;
    int unsigned r;
    lim = managed_pages();
    r = $urandom_range(0, 99);
    it.mode = MODE_FREE;
    it.page_index = PAGE_W'($urandom);
    if (r < 45) begin
      it.mode = MODE_ALLOC;
    end else if (r < 75) begin
      it.page_index = PAGE_W'(pick_busy_page(lim));
    end else if (r < 87) begin
      // free of any index, out of range when the total is small
    end else if (r < 92) begin
      if (lim > 0) it.page_index = PAGE_W'($urandom_range(0, lim - 1));
    end else if (r < 96) begin
      it.mode = MODE_INIT;
    end else if (r < 98) begin
      it.mode = MODE_UNUSED;
    end else begin
      // right at the edge of the managed range
      it.page_index = PAGE_W'(lim - $urandom_range(0, 1));
    end
    return it;
  endfunction

  // one input transfer; the expectation is queued at the accepting edge
  task automatic send_item(in_t it, bit typed, out_t want);
    out_t guess;
    int   gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    guess = step_allocator(it);
    pending_results.push_back(typed ? want : guess);
    items_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // hold the sender off until every pending result has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // register write, only called while idle
  task automatic write_reg(logic sel, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (sel == CFG_TOTAL) total_reg = val;
    else reserved_reg = val;
    settings_used++;
  endtask

  function automatic void add_item(logic [1:0] mode, int idx, bit typed,
                                   int page, logic [1:0] st, int cnt);
    stim_row_t row;
    row = '{cfg_row: 1'b0, cfg_sel: CFG_TOTAL, cfg_val: '0, item: '0,
            typed: typed, want: '0};
    row.item.mode = mode;
    row.item.page_index = PAGE_W'(idx);
    row.want.result_page = PAGE_W'(page);
    row.want.status = st;
    row.want.allocated_count = COUNT_W'(cnt);
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic sel, int val);
    stim_row_t row;
    row = '{cfg_row: 1'b1, cfg_sel: sel, cfg_val: CFG_W'(val), item: '0,
            typed: 1'b0, want: '0};
    dir_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------
  // receiver: stall stretches of random length, with some long quiet runs
  // ---------------------------------------------------------------------
  initial begin : drive_out_stall
    int unsigned r;
    int          len;
    logic        hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (r < 5) begin
        hold = 1'b0;
        len = 200;
      end else if (r < 70) begin
        hold = 1'b0;
        len = $urandom_range(1, 20);
      end else if (r < 95) begin
        hold = 1'b1;
        len = $urandom_range(1, 3);
      end else begin
        hold = 1'b1;
        len = $urandom_range(10, 40);
      end
      out_stall <= hold;
      repeat (len - 1) @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------

  // random phases: total, reserve and whether the phase opens with an
  // initialize; the phase without initialize after a full-size one shrinks
  // the total under pages still in use
  int unsigned phase_total    [RAND_PHASES] = '{8, 64, 4096, 20, 0, 1, 130, 8191, 37, 4096, 100};
  int unsigned phase_reserved [RAND_PHASES] = '{0, 3, 1, 2, 5, 1, 200, 4000, 2, 4096, 0};
  bit          phase_init     [RAND_PHASES] = '{1, 1, 1, 0, 0, 1, 1, 1, 1, 1, 1};

  initial begin : run_test
    in_t it;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_TOTAL;
    cfg_wdata = '0;
    rst_n     = 1'b0;

    page_busy    = '{default: 1'b0};
    pages_in_use = 0;
    total_reg    = CFG_W'(4096);
    reserved_reg = CFG_W'(1);

    // directed table; hand-written results where they follow directly
    // from the reset state, the extremes or the error codes
    add_item(MODE_ALLOC,  0,    1, 0,    ST_OK,    1);  // bitmap empty after reset
    add_item(MODE_INIT,   0,    1, 0,    ST_OK,    1);
    add_item(MODE_ALLOC,  0,    1, 1,    ST_OK,    2);
    add_item(MODE_ALLOC,  0,    1, 2,    ST_OK,    3);
    add_item(MODE_FREE,   4095, 1, 4095, ST_FREE,  3);
    add_item(MODE_FREE,   1,    1, 1,    ST_OK,    2);
    add_item(MODE_FREE,   1,    1, 1,    ST_FREE,  2);  // double free
    add_item(MODE_ALLOC,  0,    1, 1,    ST_OK,    3);
    add_item(MODE_UNUSED, 4095, 1, 0,    ST_OK,    3);
    add_item(MODE_FREE,   0,    1, 0,    ST_OK,    2);  // reserved page may be freed
    add_item(MODE_ALLOC,  0,    1, 0,    ST_OK,    3);
    add_cfg(CFG_TOTAL, 8);
    add_cfg(CFG_RESERVED, 4);
    add_item(MODE_INIT,   0,    1, 0,    ST_OK,    4);
    add_item(MODE_ALLOC,  0,    0, 0,    ST_OK,    0);
    add_item(MODE_ALLOC,  0,    0, 0,    ST_OK,    0);
    add_item(MODE_ALLOC,  0,    0, 0,    ST_OK,    0);
    add_item(MODE_ALLOC,  0,    1, 7,    ST_OK,    8);  // last page of the total
    add_item(MODE_ALLOC,  0,    1, 0,    ST_OOM,   8);
    add_item(MODE_FREE,   8,    1, 8,    ST_RANGE, 8);
    add_item(MODE_FREE,   4095, 1, 4095, ST_RANGE, 8);
    add_cfg(CFG_TOTAL, 0);                               // no pages at all
    add_item(MODE_ALLOC,  0,    1, 0,    ST_OOM,   8);
    add_item(MODE_FREE,   0,    1, 0,    ST_RANGE, 8);
    add_cfg(CFG_TOTAL, 8191);                            // clipped to the bitmap
    add_cfg(CFG_RESERVED, 8191);                         // clipped to the total
    add_item(MODE_INIT,   0,    1, 0,    ST_OK,    4096);
    add_item(MODE_ALLOC,  0,    1, 0,    ST_OOM,   4096);
    add_item(MODE_FREE,   4095, 1, 4095, ST_OK,    4095);
    add_item(MODE_ALLOC,  0,    1, 4095, ST_OK,    4096); // full-depth scan

    // hold reset, then release it at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[n]) begin
      if (dir_rows[n].cfg_row) begin
        wait_idle();
        write_reg(dir_rows[n].cfg_sel, dir_rows[n].cfg_val);
      end else begin
        send_item(dir_rows[n].item, dir_rows[n].typed, dir_rows[n].want);
      end
    end

    // random phases, each under its own register setting
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      write_reg(CFG_TOTAL, CFG_W'(phase_total[p]));
      write_reg(CFG_RESERVED, CFG_W'(phase_reserved[p]));
      if (phase_init[p]) begin
        it.mode = MODE_INIT;
        it.page_index = PAGE_W'($urandom);
        send_item(it, 1'b0, '0);
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_item(pick_random_item(), 1'b0, '0);
        // sender holds off until the block has drained, now and then
        if ((p == 2 && k == 50) || $urandom_range(0, 199) == 0) wait_idle();
      end
    end

    // drain, then give a late or extra result time to show up
    wait_idle();
    repeat (200) @(posedge clk);

    $display("covered %0d input transfers and %0d result transfers over %0d register writes",
             items_sent, results_seen, settings_used);
    $display("statuses seen: ok %0d, out of memory %0d, out of range %0d, already free %0d",
             status_seen[ST_OK], status_seen[ST_OOM], status_seen[ST_RANGE],
             status_seen[ST_FREE]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog well beyond the slowest correct run
  initial begin : watchdog
    #15_000_000;
    $display("timeout waiting for the block");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
src/bpa_pkg.sv
src/bpa_ram.sv
src/bpa_ctrl.sv
src/bpa_dp.sv
src/bitmap_page_allocator.sv
tb/bitmap_page_allocator_tb.sv
